// ----- rtl/core/ftrm_pkg.sv -----
`timescale 1ns / 1ps
package ftrm_pkg;

    localparam int NUM_FANS   = 5;
    localparam int RING_DEPTH = 10;

    localparam int TIME_W = 32;
    localparam int RATE_W = 21;
    localparam int PPR_W  = 4;
    localparam int RPM_W  = 16;
    localparam int FAN_W  = 4;
    localparam int CMD_W  = 2;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam int FAN_IDX_W = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
    localparam int SLOT_W    = $clog2(RING_DEPTH);
    localparam int MEM_DEPTH = NUM_FANS * RING_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // rpm numerator is tick_rate * 60 * (RING_DEPTH - 1)
    localparam int NUM_SCALE = 60 * (RING_DEPTH - 1);
    localparam int SCALE_W   = $clog2(NUM_SCALE + 1);
    localparam int NUM_W     = RATE_W + SCALE_W;
    localparam int DEN_W     = TIME_W + PPR_W;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam int IN_TDATA_W  = ((FAN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RPM_W + FAN_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RPM_W - FAN_W;
    localparam int IN_PAD_W    = IN_TDATA_W - FAN_W;

    localparam logic [RPM_W-1:0]  RPM_MAX        = {RPM_W{1'b1}};
    localparam logic [RATE_W-1:0] TICK_RATE_RST  = RATE_W'(32768);
    localparam logic [TIME_W-1:0] STALL_TICKS_RST = TIME_W'(1638);
    localparam logic [PPR_W-1:0]  PPR_RST        = PPR_W'(2);

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEWEST,
        S_OLDEST,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W:0] n;
        n = {1'b0, s} + (SLOT_W+1)'(1);
        return (n >= (SLOT_W+1)'(RING_DEPTH)) ? '0 : n[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [FAN_IDX_W-1:0] f,
                                                    input logic [SLOT_W-1:0] s);
        return ADDR_W'(int'(f) * RING_DEPTH + int'(s));
    endfunction

endpackage

// ----- rtl/core/ftrm_edge_ram.sv -----
`timescale 1ns / 1ps
module ftrm_edge_ram import ftrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ram_wr           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [TIME_W-1:0] o_rd_data
);

    logic [TIME_W-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [TIME_W-1:0] r_q;
    logic              r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_q_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_q_valid ? r_q : '0;

endmodule

// ----- rtl/core/ftrm_divider.sv -----
`timescale 1ns / 1ps
module ftrm_divider import ftrm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [DEN_W-1:0]     r_div;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    // one restoring step: bring down the next dividend bit, try the subtract
    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = shifted - {1'b0, r_div};
        fits    = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], fits};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- rtl/core/fan_tachometer_rpm_monitor.sv -----
`timescale 1ns / 1ps
// Fan tachometer monitor for NUM_FANS fans. Each input beat carries a command in tuser
// (tick, edge, read) and a fan index in tdata. A tick advances the 32-bit time base
// and an edge stamps the time into the fan's ring of RING_DEPTH edge times; both leave
// the monitor idle, so ticks and edges may stream back to back. A read answers with one
// output beat: rpm = 60 * tick_rate * (RING_DEPTH - 1) / (pulses_per_rev * span), cut
// to 65535, or rpm 0 with the stall flag when the newest edge is older than stall_ticks.
// A full read runs S_NEWEST, S_OLDEST, S_START and S_DIV, where the bit-serial divider
// resolves one of NUM_W quotient bits per cycle; a stalled read skips to S_DONE from
// S_NEWEST, a zero-span read from S_OLDEST, a bad fan from S_IDLE. tready stays low while
// a read is in work. The edge-time memory reads as zero after reset with no clearing pass.
module fan_tachometer_rpm_monitor import ftrm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [3:0] fan, rest zero
    input  logic [CMD_W-1:0]       s_axis_tuser,  // [1:0] command
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] rpm, [19:16] fan_echo, rest zero
    output logic                   m_axis_tuser   // [0] stalled
);

    t_state r_state, n_state;

    logic [RATE_W-1:0] r_tick_rate;
    logic [TIME_W-1:0] r_stall_ticks;
    logic [PPR_W-1:0]  r_ppr;

    logic [TIME_W-1:0] r_time;
    logic [SLOT_W-1:0] r_newest [NUM_FANS];

    logic [FAN_W-1:0]  r_fan;
    logic [SLOT_W-1:0] r_old_slot;
    logic [TIME_W-1:0] r_newest_time;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [RPM_W-1:0]  r_rpm;
    logic              r_stalled;

    logic              r_out_valid;
    logic [RPM_W-1:0]  r_out_rpm;
    logic              r_out_stalled;
    logic [FAN_W-1:0]  r_out_fan;

    logic [FAN_W-1:0]     in_fan;
    logic [CMD_W-1:0]     in_cmd;
    logic                 in_accept;
    logic                 in_fan_ok;
    logic [FAN_IDX_W-1:0] in_fan_idx;
    logic [FAN_IDX_W-1:0] cur_fan_idx;
    logic [SLOT_W-1:0]    in_newest;

    t_ram_wr           ram_wr;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [TIME_W-1:0] ram_rd_data;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [TIME_W-1:0] age;
    logic              is_stall;
    logic [TIME_W-1:0] span;
    logic [PPR_W-1:0]  ppr_eff;
    logic              out_free;
    logic [RPM_W-1:0]  quo_sat;

    assign in_fan      = s_axis_tdata[FAN_W-1:0];
    assign in_cmd      = s_axis_tuser;
    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign in_fan_ok   = ({1'b0, in_fan} < (FAN_W+1)'(NUM_FANS));
    assign in_fan_idx  = in_fan_ok ? FAN_IDX_W'(in_fan) : '0;
    assign cur_fan_idx = FAN_IDX_W'(r_fan);
    assign in_newest   = r_newest[in_fan_idx];

    assign age      = r_time - ram_rd_data;
    assign is_stall = (age > r_stall_ticks);
    assign span     = r_newest_time - ram_rd_data;
    assign ppr_eff  = (r_ppr == '0) ? PPR_W'(1) : r_ppr;
    assign out_free = !r_out_valid || m_axis_tready;
    assign quo_sat  = (|div_rsp.quotient[NUM_W-1:RPM_W]) ? RPM_MAX
                                                          : div_rsp.quotient[RPM_W-1:0];

    ftrm_edge_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ram_wr),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    ftrm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        s_axis_tready    = 1'b0;
        ram_wr.en        = 1'b0;
        ram_wr.addr      = slot_addr(in_fan_idx, next_slot(in_newest));
        ram_wr.data      = r_time;
        ram_rd_addr      = '0;
        div_req.start    = 1'b0;
        div_req.dividend = r_num;
        div_req.divisor  = r_den;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                ram_rd_addr   = slot_addr(in_fan_idx, in_newest);
                if (in_accept) begin
                    unique case (in_cmd)
                        CMD_EDGE: ram_wr.en = in_fan_ok;
                        CMD_READ: n_state   = in_fan_ok ? S_NEWEST : S_DONE;
                        default: ;
                    endcase
                end
            end
            S_NEWEST: begin
                ram_rd_addr = slot_addr(cur_fan_idx, r_old_slot);
                n_state     = is_stall ? S_DONE : S_OLDEST;
            end
            S_OLDEST: begin
                n_state = (span == '0) ? S_DONE : S_START;
            end
            S_START: begin
                div_req.start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration, time base and newest-slot pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate   <= TICK_RATE_RST;
            r_stall_ticks <= STALL_TICKS_RST;
            r_ppr         <= PPR_RST;
            r_time        <= '0;
            for (int i = 0; i < NUM_FANS; i++) begin
                r_newest[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_TICK_RATE:      r_tick_rate   <= i_cfg_data[RATE_W-1:0];
                    CFG_STALL_TICKS:    r_stall_ticks <= i_cfg_data[TIME_W-1:0];
                    CFG_PULSES_PER_REV: r_ppr         <= i_cfg_data[PPR_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept && in_cmd == CMD_TICK) begin
                r_time <= r_time + TIME_W'(1);
            end
            if (ram_wr.en) begin
                r_newest[in_fan_idx] <= next_slot(in_newest);
            end
        end
    end

    // per-read working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_fan      <= in_fan;
                r_old_slot <= next_slot(in_newest);
                r_rpm      <= '0;
                r_stalled  <= 1'b1;
            end
            S_NEWEST: begin
                r_newest_time <= ram_rd_data;
                r_num         <= NUM_W'(r_tick_rate) * NUM_W'(NUM_SCALE);
                r_stalled     <= is_stall;
            end
            S_OLDEST: begin
                r_den <= DEN_W'(ppr_eff) * DEN_W'(span);
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    r_rpm <= quo_sat;
                end
            end
            default: ;
        endcase
    end

    // output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_rpm     <= r_rpm;
            r_out_stalled <= r_stalled;
            r_out_fan     <= r_fan;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_fan, r_out_rpm};
    assign m_axis_tuser  = r_out_stalled;

`ifndef SYNTH
    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_cmd == CMD_TICK) |=> (r_time == $past(r_time) + TIME_W'(1)))
        else $error("time base did not advance on a tick beat");

    a_stall_zero_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stalled) |-> (r_out_rpm == '0))
        else $error("stalled result carries nonzero rpm");

    a_bad_fan_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ({1'b0, r_out_fan} >= (FAN_W+1)'(NUM_FANS))) |-> r_out_stalled)
        else $error("read of a missing fan not flagged as stalled");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import ftrm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES    = 50;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int ITEMS_PER_PHASE  = 165;
    localparam int NUM_PHASES       = 6;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct {
        logic [RPM_W-1:0] rpm;
        logic             stalled;
        logic [FAN_W-1:0] fan;
    } t_rpm_reading;

    typedef struct {
        bit                   is_cfg;
        logic [CMD_W-1:0]     cmd;
        logic [FAN_W-1:0]     fan;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     value;
        bit                   typed;
        logic [RPM_W-1:0]     rpm;
        logic                 stalled;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [3:0] fan, rest zero
    logic [CMD_W-1:0]       s_axis_tuser  = '0;  // [1:0] command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [15:0] rpm, [19:16] fan_echo, rest zero
    logic                   m_axis_tuser;        // [0] stalled

    fan_tachometer_rpm_monitor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // tachometer shadow state
    logic [TIME_W-1:0] tach_time;
    logic [TIME_W-1:0] stamp_ring [NUM_FANS][RING_DEPTH];
    int unsigned       newest_idx [NUM_FANS];
    logic [RATE_W-1:0] rate_cfg;
    logic [TIME_W-1:0] stall_cfg;
    logic [PPR_W-1:0]  ppr_cfg;

    t_rpm_reading pending_readings [$];

    int          mismatch_count = 0;
    longint      cycle_count    = 0;
    int unsigned tick_beats     = 0;
    int unsigned stamp_beats    = 0;
    int unsigned read_beats     = 0;
    int unsigned stalled_seen   = 0;
    int unsigned saturated_seen = 0;
    bit          tx_gaps_on     = 1'b1;
    logic        long_hold_req  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("fan_tachometer_rpm_monitor verification failed");
        $finish;
    end

    // Apply one beat to the shadow state; returns 1 when it yields a reading.
    function automatic bit tach_step(input logic [CMD_W-1:0] cmd,
                                     input logic [FAN_W-1:0] fan,
                                     output t_rpm_reading r);
        bit                produced;
        int unsigned       nw;
        int unsigned       od;
        logic [TIME_W-1:0] newest;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] span;
        longint unsigned   num;
        longint unsigned   ppr;
        longint unsigned   q;
        produced  = 1'b0;
        r.rpm     = '0;
        r.stalled = 1'b1;
        r.fan     = fan;
        case (cmd)
            CMD_TICK: begin
                tach_time = tach_time + TIME_W'(1);
            end
            CMD_EDGE: begin
                if (int'(fan) < NUM_FANS) begin
                    nw = (newest_idx[fan] + 1 >= RING_DEPTH) ? 0 : newest_idx[fan] + 1;
                    newest_idx[fan]     = nw;
                    stamp_ring[fan][nw] = tach_time;
                end
            end
            CMD_READ: begin
                produced = 1'b1;
                if (int'(fan) < NUM_FANS) begin
                    nw     = newest_idx[fan];
                    od     = (nw + 1 >= RING_DEPTH) ? 0 : nw + 1;
                    newest = stamp_ring[fan][nw];
                    age    = tach_time - newest;
                    if (age <= stall_cfg) begin
                        r.stalled = 1'b0;
                        span      = newest - stamp_ring[fan][od];
                        if (span != '0) begin
                            ppr = (ppr_cfg == '0) ? 64'd1 : 64'(ppr_cfg);
                            num = 64'(rate_cfg) * 64'(60 * (RING_DEPTH - 1));
                            q   = num / (ppr * 64'(span));
                            r.rpm = (q > 64'(RPM_MAX)) ? RPM_MAX : q[RPM_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        return produced;
    endfunction

    function automatic t_stim_row item_row(input logic [CMD_W-1:0] cmd,
                                           input logic [FAN_W-1:0] fan);
        t_stim_row row;
        row        = '{default: '0};
        row.cmd    = cmd;
        row.fan    = fan;
        return row;
    endfunction

    function automatic t_stim_row chk_row(input logic [CMD_W-1:0] cmd,
                                          input logic [FAN_W-1:0] fan,
                                          input logic [RPM_W-1:0] rpm,
                                          input logic stalled);
        t_stim_row row;
        row         = item_row(cmd, fan);
        row.typed   = 1'b1;
        row.rpm     = rpm;
        row.stalled = stalled;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        t_stim_row row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = val;
        return row;
    endfunction

    task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic [FAN_W-1:0] fan,
                             input bit typed, input t_rpm_reading typed_val);
        t_rpm_reading got;
        bit           produced;
        int unsigned  pick;
        int unsigned  gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(fan);
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        produced = tach_step(cmd, fan, got);
        if (produced) pending_readings.push_back(typed ? typed_val : got);
        if (cmd == CMD_TICK) tick_beats++;
        if (cmd == CMD_EDGE) stamp_beats++;
        if (cmd == CMD_READ) read_beats++;
        if (tx_gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) gap = 0;
            else if (pick < 95) gap = $urandom_range(1, 3);
            else gap = $urandom_range(10, 40);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drain outstanding reads and let the pipeline go quiet, then write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TICK_RATE:      rate_cfg  = val[RATE_W-1:0];
            CFG_STALL_TICKS:    stall_cfg = val[TIME_W-1:0];
            CFG_PULSES_PER_REV: ppr_cfg   = val[PPR_W-1:0];
            default: ;
        endcase
    endtask

    initial begin : rx_side
        int unsigned pick;
        int unsigned n;
        forever begin
            if (long_hold_req) begin
                long_hold_req <= 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(1, 30);
                end else if (pick < 60) begin
                    m_axis_tready <= 1'b1;
                    n = 200;
                end else if (pick < 95) begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(1, 4);
                end else begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(20, 60);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : reading_check
        t_rpm_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected output beat: rpm %0d stalled %0d fan_echo %0d",
                       m_axis_tdata[RPM_W-1:0], m_axis_tuser, m_axis_tdata[RPM_W +: FAN_W]);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_axis_tdata[RPM_W-1:0] !== want.rpm) begin
                    $error("rpm: expected %0d, got %0d", want.rpm, m_axis_tdata[RPM_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.stalled) begin
                    $error("stalled: expected %0d, got %0d", want.stalled, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[RPM_W +: FAN_W] !== want.fan) begin
                    $error("fan_echo: expected %0d, got %0d", want.fan,
                           m_axis_tdata[RPM_W +: FAN_W]);
                    mismatch_count++;
                end
                if (want.stalled) stalled_seen++;
                if (want.rpm == RPM_MAX) saturated_seen++;
            end
        end
    end

    initial begin : stim
        t_stim_row         dir_rows [$];
        t_rpm_reading      typed_val;
        t_rpm_reading      none;
        int unsigned       period [NUM_FANS];
        int unsigned       countdown [NUM_FANS];
        int                counted;
        logic [FAN_W-1:0]  f_pick;
        logic [RATE_W-1:0] p_rate;
        logic [TIME_W-1:0] p_stall;
        logic [PPR_W-1:0]  p_ppr;

        none = '{rpm: '0, stalled: 1'b0, fan: '0};
        tach_time = '0;
        for (int f = 0; f < NUM_FANS; f++) begin
            newest_idx[f] = 0;
            for (int s = 0; s < RING_DEPTH; s++) stamp_ring[f][s] = '0;
        end
        rate_cfg  = TICK_RATE_RST;
        stall_cfg = STALL_TICKS_RST;
        ppr_cfg   = PPR_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty rings read as zero span, not stalled
        dir_rows.push_back(chk_row(CMD_READ, 4'd0, 16'd0, 1'b0));
        dir_rows.push_back(chk_row(CMD_READ, 4'd15, 16'd0, 1'b1));
        dir_rows.push_back(item_row(CMD_UNUSED, 4'd9));
        dir_rows.push_back(item_row(CMD_EDGE, 4'd0));
        dir_rows.push_back(item_row(CMD_TICK, 4'd15));
        dir_rows.push_back(item_row(CMD_EDGE, 4'd0));
        // one-tick span saturates
        dir_rows.push_back(chk_row(CMD_READ, 4'd0, RPM_MAX, 1'b0));
        dir_rows.push_back(item_row(CMD_EDGE, 4'd15));
        dir_rows.push_back(item_row(CMD_EDGE, 4'd5));
        dir_rows.push_back(chk_row(CMD_READ, 4'd5, 16'd0, 1'b1));
        dir_rows.push_back(chk_row(CMD_READ, 4'd4, 16'd0, 1'b0));
        dir_rows.push_back(cfg_row(CFG_STALL_TICKS, 32'd1));
        dir_rows.push_back(item_row(CMD_TICK, 4'd0));
        dir_rows.push_back(item_row(CMD_TICK, 4'd10));
        dir_rows.push_back(chk_row(CMD_READ, 4'd0, 16'd0, 1'b1));
        dir_rows.push_back(item_row(CMD_EDGE, 4'd0));
        dir_rows.push_back(item_row(CMD_READ, 4'd0));
        dir_rows.push_back(cfg_row(CFG_STALL_TICKS, 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row(CFG_TICK_RATE, 32'd0));
        dir_rows.push_back(chk_row(CMD_READ, 4'd0, 16'd0, 1'b0));
        dir_rows.push_back(cfg_row(CFG_TICK_RATE, 32'd1));
        dir_rows.push_back(cfg_row(CFG_PULSES_PER_REV, 32'd0));
        dir_rows.push_back(item_row(CMD_READ, 4'd0));
        dir_rows.push_back(cfg_row(CFG_PULSES_PER_REV, 32'd8));
        dir_rows.push_back(cfg_row(CFG_TICK_RATE, 32'h001F_FFFF));
        dir_rows.push_back(item_row(CMD_READ, 4'd0));
        dir_rows.push_back(item_row(CMD_READ, 4'd3));
        dir_rows.push_back(item_row(CMD_UNUSED, 4'd6));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                typed_val = '{rpm: dir_rows[i].rpm, stalled: dir_rows[i].stalled,
                              fan: dir_rows[i].fan};
                push_beat(dir_rows[i].cmd, dir_rows[i].fan, dir_rows[i].typed, typed_val);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin p_rate = 21'd32768;   p_stall = 32'd1638;       p_ppr = 4'd2; end
                1: begin p_rate = 21'd1;       p_stall = 32'd1;          p_ppr = 4'd1; end
                2: begin p_rate = 21'd1048576; p_stall = 32'hFFFF_FFFF;  p_ppr = 4'd8; end
                4: begin p_rate = 21'd60000;   p_stall = 32'd25;         p_ppr = 4'd4; end
                default: begin
                    p_rate  = RATE_W'($urandom_range(1, 1048576));
                    p_stall = $urandom_range(1, 400);
                    p_ppr   = PPR_W'($urandom_range(0, 8));
                end
            endcase
            write_reg(CFG_TICK_RATE, CFG_W'(p_rate));
            write_reg(CFG_STALL_TICKS, p_stall);
            write_reg(CFG_PULSES_PER_REV, CFG_W'(p_ppr));
            tx_gaps_on = (ph != 1) && (ph != 4);
            // starve the output once so a read backs up the input side
            if (ph == 2) long_hold_req <= 1'b1;

            for (int f = 0; f < NUM_FANS; f++) begin
                if ($urandom_range(0, 9) == 0) period[f] = 5000;
                else if ($urandom_range(0, 3) == 0) period[f] = $urandom_range(40, 300);
                else period[f] = $urandom_range(1, 20);
                countdown[f] = $urandom_range(1, period[f]);
            end

            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                push_beat(CMD_TICK, FAN_W'($urandom_range(0, 15)), 1'b0, none);
                counted++;
                for (int f = 0; f < NUM_FANS; f++) begin
                    if (countdown[f] <= 1) begin
                        push_beat(CMD_EDGE, FAN_W'(f), 1'b0, none);
                        counted++;
                        countdown[f] = period[f] + $urandom_range(0, 2);
                    end else begin
                        countdown[f]--;
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 9) == 0) f_pick = FAN_W'($urandom_range(NUM_FANS, 15));
                    else f_pick = FAN_W'($urandom_range(0, NUM_FANS - 1));
                    push_beat(CMD_READ, f_pick, 1'b0, none);
                    counted++;
                end
                // stray beats: unused commands and out-of-pattern edges
                if ($urandom_range(0, 19) == 0) begin
                    f_pick = FAN_W'($urandom_range(0, 15));
                    if ($urandom_range(0, 1) == 0) begin
                        push_beat(CMD_UNUSED, f_pick, 1'b0, none);
                    end else begin
                        push_beat(CMD_EDGE, f_pick, 1'b0, none);
                        if (int'(f_pick) < NUM_FANS) counted++;
                    end
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d tick, %0d edge and %0d read beats over %0d register settings.",
                 tick_beats, stamp_beats, read_beats, NUM_PHASES + 1);
        $display("Readings checked: %0d stalled, %0d saturated, %0d mismatches.",
                 stalled_seen, saturated_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("fan_tachometer_rpm_monitor verification clean");
        end else begin
            $display("fan_tachometer_rpm_monitor verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ftrm_pkg.sv
rtl/core/ftrm_edge_ram.sv
rtl/core/ftrm_divider.sv
rtl/core/fan_tachometer_rpm_monitor.sv
bench/tb.sv
